// ===== rtl/core/pair_event_target_counter_table_assert.svh =====
`ifndef PAIR_EVENT_TARGET_COUNTER_TABLE_ASSERT_SVH
`define PAIR_EVENT_TARGET_COUNTER_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PET_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pet assertion failed");

// Next-cycle implication, checked out of reset.
`define PET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pet assertion failed");

`endif

// ===== rtl/core/pet_pkg.sv =====
`timescale 1ns / 1ps

package pet_pkg;

    localparam int SLOTS      = 64;
    localparam int COUNT_BITS = 16;
    localparam int ID_BITS    = 16;
    localparam int TYPE_W     = 3;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int USED_W     = $clog2(SLOTS + 1);

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [USED_W-1:0]     t_used;
    typedef logic [TYPE_W-1:0]     t_wtype;

    localparam t_used  SLOTS_U        = USED_W'(SLOTS);
    localparam t_count COUNT_MAX      = '1;
    localparam t_wtype ALL_PAIRS_TYPE = '0;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_INC   = 3'd1,
        ACT_DEC   = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_QUERY = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MODIFY,
        S_CLEAR,
        S_RESP
    } t_state;

    typedef struct packed {
        t_wtype                    wtype;
        logic signed [ID_BITS-1:0] lo;
        logic signed [ID_BITS-1:0] hi;
    } t_key;

    typedef struct packed {
        t_key   key;
        t_count target;
    } t_key_word;

    typedef struct packed {
        t_count current;
        logic   mark;
    } t_cnt_word;

    typedef struct packed {
        logic      key_re;
        t_idx      key_raddr;
        logic      key_we;
        t_idx      key_waddr;
        t_key_word key_wdata;
        logic      cnt_re;
        t_idx      cnt_raddr;
        logic      cnt_we;
        t_idx      cnt_waddr;
        t_cnt_word cnt_wdata;
    } t_store_req;

    typedef struct packed {
        t_status status;
        t_count  target;
        t_count  current;
        logic    mark;
    } t_result;

endpackage

// ===== rtl/core/pet_if.sv =====
`timescale 1ns / 1ps

interface pet_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [2:0]        watch_type;
    logic signed [15:0] id_a;
    logic signed [15:0] id_b;
    logic [15:0]       target_count;

    modport source (output valid, action, watch_type, id_a, id_b, target_count, input ready);
    modport sink (input valid, action, watch_type, id_a, id_b, target_count, output ready);
endinterface

interface pet_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] target_out;
    logic [15:0] current_out;
    logic        entry_done;
    logic        all_done;
    logic        all_pairs_watched;

    modport source (
        output valid, status, target_out, current_out, entry_done, all_done,
               all_pairs_watched,
        input  ready
    );
    modport sink (
        input  valid, status, target_out, current_out, entry_done, all_done,
               all_pairs_watched,
        output ready
    );
endinterface

// ===== rtl/core/pet_store.sv =====
`timescale 1ns / 1ps

module pet_store (
    input  logic                  i_clk,
    input  pet_pkg::t_store_req   i_req,
    output pet_pkg::t_key_word    o_key_rd,
    output pet_pkg::t_cnt_word    o_cnt_rd
);

    pet_pkg::t_key_word r_key_mem [pet_pkg::SLOTS];
    pet_pkg::t_cnt_word r_cnt_mem [pet_pkg::SLOTS];
    pet_pkg::t_key_word r_key_rd;
    pet_pkg::t_cnt_word r_cnt_rd;

    // key and target per slot
    always_ff @(posedge i_clk) begin
        if (i_req.key_we) begin
            r_key_mem[i_req.key_waddr] <= i_req.key_wdata;
        end
        if (i_req.key_re) begin
            r_key_rd <= r_key_mem[i_req.key_raddr];
        end
    end

    // count and mark per slot
    always_ff @(posedge i_clk) begin
        if (i_req.cnt_we) begin
            r_cnt_mem[i_req.cnt_waddr] <= i_req.cnt_wdata;
        end
        if (i_req.cnt_re) begin
            r_cnt_rd <= r_cnt_mem[i_req.cnt_raddr];
        end
    end

    assign o_key_rd = r_key_rd;
    assign o_cnt_rd = r_cnt_rd;

endmodule

// ===== rtl/core/pair_event_target_counter_table.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// i_req    in   valid / ready  action, watch_type, id_a, id_b, target_count
// o_rsp    out  valid / ready  status, target_out, current_out, entry_done, all_done,
//                              all_pairs_watched
//
// One request at a time. Key search reads the key memory one slot per cycle;
// set, increment, decrement and query search the used slots, a miss or an insert ends
// the search after the last used slot, clear rewrites the count of each used slot,
// and unused actions go straight to the response; any response may wait on o_rsp.ready.
// Slots fill in order and are never freed, so the fill count stands for valid bits.
// Reset is synchronous and active low; no memory clearing pass is needed.
// A new request is taken while the previous response still waits in the output register.

`include "pair_event_target_counter_table_assert.svh"

module pair_event_target_counter_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pet_req_if.sink    i_req,
    pet_rsp_if.source  o_rsp
);

    pet_pkg::t_state     r_state, n_state;
    pet_pkg::t_action    r_act, n_act;
    pet_pkg::t_key       r_key, n_key;
    pet_pkg::t_count     r_tgt_in, n_tgt_in;
    pet_pkg::t_used      r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    pet_pkg::t_idx       r_cmp_idx, n_cmp_idx;
    pet_pkg::t_idx       r_slot, n_slot;
    pet_pkg::t_count     r_tgt, n_tgt;
    pet_pkg::t_used      r_used, n_used;
    pet_pkg::t_used      r_done, n_done;
    logic                r_wild, n_wild;
    pet_pkg::t_result    r_res, n_res;
    logic                r_out_vld, n_out_vld;
    pet_pkg::t_result    r_out, n_out;
    logic                r_out_all, n_out_all;
    logic                r_out_wild, n_out_wild;

    pet_pkg::t_store_req w_store;
    pet_pkg::t_key_word  w_key_rd;
    pet_pkg::t_cnt_word  w_cnt_rd;

    logic signed [pet_pkg::ID_BITS-1:0] w_a;
    logic signed [pet_pkg::ID_BITS-1:0] w_b;
    pet_pkg::t_key       w_key_in;
    logic                w_accept;
    logic                w_match;
    pet_pkg::t_count     w_cur_up;
    pet_pkg::t_count     w_cur_dn;

    pet_store u_store (
        .i_clk    (i_clk),
        .i_req    (w_store),
        .o_key_rd (w_key_rd),
        .o_cnt_rd (w_cnt_rd)
    );

    assign w_a = i_req.id_a[pet_pkg::ID_BITS-1:0];
    assign w_b = i_req.id_b[pet_pkg::ID_BITS-1:0];

    always_comb begin
        w_key_in.wtype = i_req.watch_type;
        w_key_in.lo    = (w_a < w_b) ? w_a : w_b;
        w_key_in.hi    = (w_a < w_b) ? w_b : w_a;
    end

    assign i_req.ready = (r_state == pet_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_match     = r_cmp_vld && (w_key_rd.key == r_key);
    assign w_cur_up    = w_cnt_rd.current + pet_pkg::t_count'(1);
    assign w_cur_dn    = w_cnt_rd.current - pet_pkg::t_count'(1);

    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_key      = r_key;
        n_tgt_in   = r_tgt_in;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_slot     = r_slot;
        n_tgt      = r_tgt;
        n_used     = r_used;
        n_done     = r_done;
        n_wild     = r_wild;
        n_res      = r_res;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out      = r_out;
        n_out_all  = r_out_all;
        n_out_wild = r_out_wild;
        w_store    = '0;

        unique case (r_state)
            pet_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_act     = pet_pkg::t_action'(i_req.action);
                    n_key     = w_key_in;
                    n_tgt_in  = i_req.target_count[pet_pkg::COUNT_BITS-1:0];
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_res     = '{status: pet_pkg::ST_OK, default: '0};
                    case (pet_pkg::t_action'(i_req.action))
                        pet_pkg::ACT_SET, pet_pkg::ACT_INC, pet_pkg::ACT_DEC,
                        pet_pkg::ACT_QUERY: begin
                            n_state = pet_pkg::S_SEARCH;
                        end
                        pet_pkg::ACT_CLEAR: begin
                            n_done  = '0;
                            n_state = pet_pkg::S_CLEAR;
                        end
                        default: begin
                            n_state = pet_pkg::S_RESP;
                        end
                    endcase
                    if (pet_pkg::t_action'(i_req.action) == pet_pkg::ACT_SET &&
                        i_req.watch_type == pet_pkg::ALL_PAIRS_TYPE) begin
                        n_wild = 1'b1;
                    end
                end
            end
            pet_pkg::S_SEARCH: begin
                if (w_match) begin
                    // fetch count and mark of the hit
                    n_slot           = r_cmp_idx;
                    n_tgt            = w_key_rd.target;
                    n_cmp_vld        = 1'b0;
                    w_store.cnt_re   = 1'b1;
                    w_store.cnt_raddr = r_cmp_idx;
                    n_state          = pet_pkg::S_MODIFY;
                end else if (r_idx == r_used) begin
                    n_cmp_vld = 1'b0;
                    n_state   = pet_pkg::S_RESP;
                    if (r_act == pet_pkg::ACT_SET) begin
                        if (r_used == pet_pkg::SLOTS_U) begin
                            n_res.status = pet_pkg::ST_FULL;
                        end else begin
                            // insert at the first free slot
                            w_store.key_we          = 1'b1;
                            w_store.key_waddr       = r_used[pet_pkg::IDX_W-1:0];
                            w_store.key_wdata.key   = r_key;
                            w_store.key_wdata.target = r_tgt_in;
                            w_store.cnt_we          = 1'b1;
                            w_store.cnt_waddr       = r_used[pet_pkg::IDX_W-1:0];
                            n_used                  = r_used + pet_pkg::t_used'(1);
                            n_res.target            = r_tgt_in;
                        end
                    end else begin
                        n_res.status = pet_pkg::ST_MISS;
                    end
                end else begin
                    w_store.key_re    = 1'b1;
                    w_store.key_raddr = r_idx[pet_pkg::IDX_W-1:0];
                    n_cmp_vld         = 1'b1;
                    n_cmp_idx         = r_idx[pet_pkg::IDX_W-1:0];
                    n_idx             = r_idx + pet_pkg::t_used'(1);
                end
            end
            pet_pkg::S_MODIFY: begin
                n_state       = pet_pkg::S_RESP;
                n_res.status  = pet_pkg::ST_OK;
                n_res.target  = r_tgt;
                n_res.current = w_cnt_rd.current;
                n_res.mark    = w_cnt_rd.mark;
                w_store.cnt_waddr = r_slot;
                case (r_act)
                    pet_pkg::ACT_SET: begin
                        w_store.key_we           = 1'b1;
                        w_store.key_waddr        = r_slot;
                        w_store.key_wdata.key    = r_key;
                        w_store.key_wdata.target = r_tgt_in;
                        n_res.target             = r_tgt_in;
                    end
                    pet_pkg::ACT_INC: begin
                        if (w_cnt_rd.current == pet_pkg::COUNT_MAX) begin
                            n_res.status = pet_pkg::ST_SAT;
                        end else begin
                            n_res.current = w_cur_up;
                            if (w_cur_up == r_tgt && !w_cnt_rd.mark) begin
                                n_res.mark = 1'b1;
                                n_done     = r_done + pet_pkg::t_used'(1);
                            end
                            w_store.cnt_we = 1'b1;
                        end
                    end
                    pet_pkg::ACT_DEC: begin
                        if (w_cnt_rd.current == '0) begin
                            n_res.status = pet_pkg::ST_SAT;
                        end else begin
                            n_res.current = w_cur_dn;
                            if (w_cnt_rd.current == r_tgt) begin
                                n_res.mark = 1'b0;
                                if (w_cnt_rd.mark) begin
                                    n_done = r_done - pet_pkg::t_used'(1);
                                end
                            end
                            w_store.cnt_we = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                w_store.cnt_wdata.current = n_res.current;
                w_store.cnt_wdata.mark    = n_res.mark;
            end
            pet_pkg::S_CLEAR: begin
                if (r_idx == r_used) begin
                    n_state = pet_pkg::S_RESP;
                end else begin
                    w_store.cnt_we    = 1'b1;
                    w_store.cnt_waddr = r_idx[pet_pkg::IDX_W-1:0];
                    n_idx             = r_idx + pet_pkg::t_used'(1);
                end
            end
            pet_pkg::S_RESP: begin
                // hold until the output register is free
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld  = 1'b1;
                    n_out      = r_res;
                    n_out_all  = (r_done == r_used);
                    n_out_wild = r_wild;
                    n_state    = pet_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pet_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pet_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
            r_used    <= '0;
            r_done    <= '0;
            r_wild    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_used    <= n_used;
            r_done    <= n_done;
            r_wild    <= n_wild;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_key      <= n_key;
        r_tgt_in   <= n_tgt_in;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_slot     <= n_slot;
        r_tgt      <= n_tgt;
        r_res      <= n_res;
        r_out      <= n_out;
        r_out_all  <= n_out_all;
        r_out_wild <= n_out_wild;
    end

    assign o_rsp.valid             = r_out_vld;
    assign o_rsp.status            = r_out.status;
    assign o_rsp.target_out        = 16'(r_out.target);
    assign o_rsp.current_out       = 16'(r_out.current);
    assign o_rsp.entry_done        = r_out.mark;
    assign o_rsp.all_done          = r_out_all;
    assign o_rsp.all_pairs_watched = r_out_wild;

    `PET_ASSERT(a_done_le_used, 1'b1, r_done <= r_used)
    `PET_ASSERT(a_used_le_slots, 1'b1, r_used <= pet_pkg::SLOTS_U)
    `PET_ASSERT_NEXT(a_used_never_falls, 1'b1, r_used >= $past(r_used))
    `PET_ASSERT_NEXT(a_wild_sticky, r_wild, r_wild)
    `PET_ASSERT(a_clear_keeps_keys, r_state == pet_pkg::S_CLEAR, !w_store.key_we)

endmodule

// ===== tb/pet_reply_checker.sv =====
`timescale 1ns / 1ps

module pet_reply_checker
    import pet_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pet_req_if   i_req,
    pet_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_miss_seen,
    output int   o_full_seen,
    output int   o_sat_seen
);

    typedef struct packed {
        t_status status;
        t_count  target;
        t_count  current;
        logic    entry_done;
        logic    all_done;
        logic    all_pairs;
    } table_reply_t;

    localparam int REPORT_CAP = 40;

    logic   row_valid  [SLOTS];
    t_key   row_key    [SLOTS];
    t_count row_target [SLOTS];
    t_count row_count  [SLOTS];
    logic   row_mark   [SLOTS];
    t_used  rows_used;
    t_used  rows_done;
    logic   wildcard_flag;

    table_reply_t due_replies[$];
    int fails;
    int reports;
    int replies;
    int misses;
    int fulls;
    int sats;

    function automatic int find_row(input t_key k);
        for (int i = 0; i < SLOTS; i++) begin
            if (row_valid[i] && row_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic int first_free_row();
        for (int i = 0; i < SLOTS; i++) begin
            if (!row_valid[i]) return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the reply it must produce.
    function automatic table_reply_t update_table(
        input logic [2:0]                act,
        input t_wtype                    wt,
        input logic signed [ID_BITS-1:0] a,
        input logic signed [ID_BITS-1:0] b,
        input t_count                    tgt
    );
        t_key         key;
        table_reply_t r;
        int           row;
        key.wtype = wt;
        key.lo    = (a < b) ? a : b;
        key.hi    = (a < b) ? b : a;
        r         = '0;
        r.status  = ST_OK;
        row       = -1;
        case (act)
            ACT_SET: begin
                // the sticky flag rises even when the insert fails
                if (wt == ALL_PAIRS_TYPE) wildcard_flag = 1'b1;
                row = find_row(key);
                if (row >= 0) begin
                    row_target[row] = tgt;
                end else begin
                    row = first_free_row();
                    if (row < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        row_valid[row]  = 1'b1;
                        row_key[row]    = key;
                        row_target[row] = tgt;
                        row_count[row]  = '0;
                        row_mark[row]   = 1'b0;
                        rows_used++;
                    end
                end
            end
            ACT_INC: begin
                row = find_row(key);
                if (row < 0) begin
                    r.status = ST_MISS;
                end else if (row_count[row] == COUNT_MAX) begin
                    r.status = ST_SAT;
                end else begin
                    row_count[row]++;
                    if (row_count[row] == row_target[row] && !row_mark[row]) begin
                        row_mark[row] = 1'b1;
                        rows_done++;
                    end
                end
            end
            ACT_DEC: begin
                row = find_row(key);
                if (row < 0) begin
                    r.status = ST_MISS;
                end else if (row_count[row] == '0) begin
                    r.status = ST_SAT;
                end else begin
                    // drop the done total only for an entry that was marked
                    if (row_count[row] == row_target[row]) begin
                        if (row_mark[row]) rows_done--;
                        row_mark[row] = 1'b0;
                    end
                    row_count[row]--;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    row_count[i] = '0;
                    row_mark[i]  = 1'b0;
                end
                rows_done = '0;
            end
            ACT_QUERY: begin
                row = find_row(key);
                if (row < 0) r.status = ST_MISS;
            end
            default: begin
            end
        endcase
        if (row >= 0) begin
            r.target     = row_target[row];
            r.current    = row_count[row];
            r.entry_done = row_mark[row];
        end
        r.all_done  = (rows_done == rows_used);
        r.all_pairs = wildcard_flag;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            if (reports < REPORT_CAP) begin
                reports++;
                $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        table_reply_t got;
        table_reply_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                row_valid[i]  = 1'b0;
                row_key[i]    = '0;
                row_target[i] = '0;
                row_count[i]  = '0;
                row_mark[i]   = 1'b0;
            end
            rows_used     = '0;
            rows_done     = '0;
            wildcard_flag = 1'b0;
            due_replies.delete();
        end else begin
            // check the reply first: a request never answers in its own cycle
            if (i_rsp.valid && i_rsp.ready) begin
                got.status     = t_status'(i_rsp.status);
                got.target     = i_rsp.target_out;
                got.current    = i_rsp.current_out;
                got.entry_done = i_rsp.entry_done;
                got.all_done   = i_rsp.all_done;
                got.all_pairs  = i_rsp.all_pairs_watched;
                replies++;
                case (got.status)
                    ST_MISS: misses++;
                    ST_FULL: fulls++;
                    ST_SAT:  sats++;
                    default: begin
                    end
                endcase
                if (due_replies.size() == 0) begin
                    fails++;
                    if (reports < REPORT_CAP) begin
                        reports++;
                        $display("%0t ns: reply with no request outstanding, status %0d",
                                 $time, i_rsp.status);
                    end
                end else begin
                    want = due_replies.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("target", want.target, i_rsp.target_out);
                    check_field("count", want.current, i_rsp.current_out);
                    check_field("entry done", want.entry_done, i_rsp.entry_done);
                    check_field("all done", want.all_done, i_rsp.all_done);
                    check_field("all pairs", want.all_pairs, i_rsp.all_pairs_watched);
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_replies.push_back(update_table(i_req.action, i_req.watch_type,
                                                   i_req.id_a, i_req.id_b,
                                                   i_req.target_count));
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_replies.size();
        o_checked    <= replies;
        o_miss_seen  <= misses;
        o_full_seen  <= fulls;
        o_sat_seen   <= sats;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pet_pkg::*;

    localparam int     CLK_HIGH_NS   = 6;
    localparam int     CLK_LOW_NS    = 6;
    localparam int     RESET_CYCLES  = 5;
    localparam longint TIMEOUT_NS    = 10_000_000;
    localparam int     PHASE_ITEMS   = 212;
    localparam int     MAIN_KEYS     = 70;
    localparam int     WILD_KEYS     = 6;
    localparam int     POOL_KEYS     = MAIN_KEYS + WILD_KEYS;
    localparam int     DIRECTED_KEYS = 4;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     SETTLE_CYCLES = SLOTS + 40;
    localparam int     COUNT_STEPS   = 3;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    localparam t_wtype WT_PAIR  = 3'd1;
    localparam t_wtype WT_MARK  = 3'd2;
    localparam t_wtype WT_SAT   = 3'd5;
    localparam t_wtype WT_OTHER = 3'd6;
    localparam t_wtype WT_SPAN  = 3'd7;

    localparam logic signed [15:0] ID_WILD = -16'sd1;
    localparam logic signed [15:0] ID_MIN  = 16'sh8000;
    localparam logic signed [15:0] ID_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] ID_NEG  = -16'sd2;
    localparam logic signed [15:0] ID_FAR  = 16'sd31000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pet_req_if req_ch ();
    pet_rsp_if rsp_ch ();

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;
    int   hold_left     = 0;
    int   sent          = 0;

    t_wtype            pool_type [POOL_KEYS];
    logic signed [15:0] pool_a   [POOL_KEYS];
    logic signed [15:0] pool_b   [POOL_KEYS];
    logic              pool_in   [MAIN_KEYS];
    int                keys_in    = DIRECTED_KEYS;
    int                next_fresh = 0;

    int fail_count;
    int pending_replies;
    int replies_checked;
    int miss_seen;
    int full_seen;
    int sat_seen;

    pair_event_target_counter_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pet_reply_checker reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_replies),
        .o_checked    (replies_checked),
        .o_miss_seen  (miss_seen),
        .o_full_seen  (full_seen),
        .o_sat_seen   (sat_seen)
    );

    always begin
        #(CLK_LOW_NS) i_clk = 1'b1;
        #(CLK_HIGH_NS) i_clk = 1'b0;
    end

    // Reply side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic issue(input logic [2:0] act, input t_wtype wt,
                         input logic signed [15:0] a, input logic signed [15:0] b,
                         input t_count tgt);
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.watch_type   <= wt;
        req_ch.id_a         <= a;
        req_ch.id_b         <= b;
        req_ch.target_count <= tgt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic issue_key(input logic [2:0] act, input int idx, input t_count tgt);
        if ($urandom_range(1))
            issue(act, pool_type[idx], pool_b[idx], pool_a[idx], tgt);
        else
            issue(act, pool_type[idx], pool_a[idx], pool_b[idx], tgt);
    endtask

    task automatic random_request();
        int         roll;
        int         pick;
        int         idx;
        logic       full;
        logic [2:0] act;
        t_count     tgt;
        full = (keys_in >= SLOTS);
        roll = $urandom_range(99);
        tgt  = ($urandom_range(99) < 85) ? t_count'($urandom_range(4)) : t_count'($urandom);
        if (roll < (full ? 15 : 30)) begin
            // all-pairs keys only once the table is full, so the flag rises on a full table
            if (full && $urandom_range(99) < 25) begin
                idx = MAIN_KEYS + $urandom_range(WILD_KEYS - 1);
            end else if (!full && $urandom_range(99) < 70) begin
                while (next_fresh < MAIN_KEYS && pool_in[next_fresh]) next_fresh++;
                idx = (next_fresh < MAIN_KEYS) ? next_fresh : $urandom_range(MAIN_KEYS - 1);
            end else begin
                idx = $urandom_range(MAIN_KEYS - 1);
            end
            if (idx < MAIN_KEYS && !pool_in[idx] && !full) begin
                pool_in[idx] = 1'b1;
                keys_in++;
            end
            issue_key(ACT_SET, idx, tgt);
        end else begin
            roll = $urandom_range(99);
            if (roll < 50)      act = ACT_INC;
            else if (roll < 78) act = ACT_DEC;
            else if (roll < 92) act = ACT_QUERY;
            else if (roll < 96) act = ACT_CLEAR;
            else                act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
            pick = $urandom_range(99);
            if (pick < 85) begin
                // favor keys already in the table
                idx = $urandom_range(MAIN_KEYS - 1);
                for (int t = 0; t < 4 && !pool_in[idx]; t++) idx = $urandom_range(MAIN_KEYS - 1);
                issue_key(act, idx, tgt);
            end else if (pick < 93) begin
                issue_key(act, $urandom_range(POOL_KEYS - 1), tgt);
            end else begin
                issue(act, t_wtype'($urandom_range(7)), 16'($urandom), 16'($urandom), tgt);
            end
        end
    endtask

    task automatic drain_replies();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_replies != 0 && waited < DRAIN_LIMIT);
    endtask

    initial begin
        int phase;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_QUERY;
        req_ch.watch_type   <= '0;
        req_ch.id_a         <= '0;
        req_ch.id_b         <= '0;
        req_ch.target_count <= '0;

        // ids of the pool keys sit in disjoint bands, so every key is distinct
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_type[i] = (i < MAIN_KEYS) ? t_wtype'($urandom_range(7, 1)) : ALL_PAIRS_TYPE;
            pool_a[i]    = 16'(i * 16 + $urandom_range(15));
            pool_b[i]    = 16'(2000 + $urandom_range(999));
        end
        for (int i = 0; i < MAIN_KEYS; i++) pool_in[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(ACT_QUERY, WT_OTHER, 16'sd5, 16'sd6, '0);
        // step one entry up, down once, clear it, then decrement the empty count
        issue(ACT_SET, WT_SAT, ID_FAR, ID_NEG, COUNT_MAX);
        for (int n = 0; n < COUNT_STEPS; n++) issue(ACT_INC, WT_SAT, ID_NEG, ID_FAR, '0);
        issue(ACT_DEC, WT_SAT, ID_FAR, ID_NEG, '0);
        issue(ACT_CLEAR, WT_SAT, ID_FAR, ID_NEG, '0);
        issue(ACT_DEC, WT_SAT, ID_FAR, ID_NEG, '0);
        issue(ACT_SET, WT_PAIR, ID_WILD, ID_WILD, 16'd1);
        issue(ACT_SET, WT_SAT, ID_NEG, ID_FAR, 16'd1);
        issue(ACT_INC, WT_SAT, ID_NEG, ID_FAR, '0);
        issue(ACT_INC, WT_PAIR, ID_WILD, ID_WILD, '0);
        issue(ACT_SET, WT_SPAN, ID_MIN, ID_MAX, 16'hA5A5);
        issue(ACT_QUERY, WT_SPAN, ID_MAX, ID_MIN, '0);
        issue(ACT_INC, WT_OTHER, ID_MIN, ID_MAX, '0);
        // raise the target past the count: the mark must survive a decrement
        issue(ACT_SET, WT_PAIR, ID_WILD, ID_WILD, 16'd3);
        issue(ACT_DEC, WT_PAIR, ID_WILD, ID_WILD, '0);
        // count meets a lowered target with no mark: decrement must not touch the total
        issue(ACT_SET, WT_MARK, 16'sd4, ID_WILD, 16'd5);
        issue(ACT_INC, WT_MARK, ID_WILD, 16'sd4, '0);
        issue(ACT_INC, WT_MARK, 16'sd4, ID_WILD, '0);
        issue(ACT_SET, WT_MARK, ID_WILD, 16'sd4, 16'd2);
        issue(ACT_DEC, WT_MARK, 16'sd4, ID_WILD, '0);
        for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++)
            issue(3'(c), t_wtype'($urandom_range(7)), 16'($urandom), 16'($urandom),
                  t_count'($urandom));
        issue(ACT_QUERY, WT_MARK, ID_WILD, 16'sd4, '0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                    hold_req     <= !hold_req;
                end
                1: begin
                    send_idle_pct = 85;
                    stall_pct    <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 85;
                end
                default: begin
                    send_idle_pct = 8;
                    stall_pct    <= 8;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) random_request();
            drain_replies();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests: directed cases, a short count run, four idle mixes.",
                 sent);
        $display("Checked %0d replies; key missing %0d, table full %0d, count saturated %0d.",
                 replies_checked, miss_seen, full_seen, sat_seen);
        if (pending_replies != 0)
            $display("%0d replies never arrived", pending_replies);
        if (fail_count == 0 && pending_replies == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out waiting on the table");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pet_pkg.sv
rtl/core/pet_if.sv
rtl/core/pet_store.sv
rtl/core/pair_event_target_counter_table.sv
tb/pet_reply_checker.sv
tb/testbench.sv
